@@ design/gbci_pkg.sv @@
`timescale 1ns / 1ps
// package: shared constants and control structs for the gyro bias / integrate core
package gbci_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
  localparam int DEG_W       = 5;
  localparam int RATE_W      = 16;
  localparam int ACC_W       = 32;
  localparam int CNT_W       = 15;

  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam logic REG_CAL_SAMPLES = 1'b0;
  localparam logic [CNT_W-1:0] CAL_SAMPLES_RST = CNT_W'(1024);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MERGE  = 4'b0010,
    S_FINISH = 4'b0100,
    S_RUN    = 4'b1000
  } state_e;

  typedef struct packed {
    logic             load;
    logic             merge;
    logic             store;
    logic             latch_bias;
    logic             acc_upd;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;
  } lane_ctl_t;

  typedef struct packed {
    logic emit;
    logic done;
    logic seen;
  } out_ctl_t;

endpackage

@@ design/gbci_in_if.sv @@
`timescale 1ns / 1ps
// interface: input rate sample channel
interface gbci_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic signed [gbci_pkg::RATE_W-1:0]    rate_x;
  logic signed [gbci_pkg::RATE_W-1:0]    rate_y;
  logic signed [gbci_pkg::RATE_W-1:0]    rate_z;

  modport source (output valid, mode, rate_x, rate_y, rate_z, input ready);
  modport sink   (input valid, mode, rate_x, rate_y, rate_z, output ready);
endinterface

@@ design/gbci_out_if.sv @@
`timescale 1ns / 1ps
// interface: orientation result channel
interface gbci_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [gbci_pkg::ACC_W-1:0]     orient_x;
  logic signed [gbci_pkg::ACC_W-1:0]     orient_y;
  logic signed [gbci_pkg::ACC_W-1:0]     orient_z;
  logic                                  cal_done;
  logic                                  bias_valid;

  modport source (output valid, orient_x, orient_y, orient_z, cal_done, bias_valid,
                  input ready);
  modport sink   (input valid, orient_x, orient_y, orient_z, cal_done, bias_valid,
                  output ready);
endinterface

@@ design/gyro_bias_calibrate_integrate_core.sv @@
`timescale 1ns / 1ps
// top level: gyro bias calibration and rate integration core
//
// Takes one three-axis rate item at a time. A calibration item (mode 0) is pushed
// onto a stack of partial averages; equal-degree neighbors are folded together one
// merge per cycle by a shared adder in each axis lane. After cal_samples calibration
// items the bottom entry becomes the bias and the stack empties. A run item (mode 1)
// subtracts the bias and adds the difference into wrapping 32-bit accumulators.
// Every item yields exactly one result carrying the three accumulators, cal_done
// and bias_valid. A run item passes through accept and update; a calibration item
// passes through accept, m merges, a store and a finish, m being the merges it causes (0 up to
// 14, since a 15-bit run length never lets more than 32766 samples pile up; on
// average about 1).
// Result back-pressure stalls the core in its final step. The x, y and z lanes run
// in parallel under one sequencer. cal_samples sits at byte address 0 of the APB
// port (reset 1024); pready is tied high.
module gyro_bias_calibrate_integrate_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  gbci_in_if.sink                             in_i,
  gbci_out_if.source                          out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gbci_pkg::APB_AW-1:0]         paddr,
  input  logic [gbci_pkg::APB_DW-1:0]         pwdata,
  output logic [gbci_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  logic [gbci_pkg::CNT_W-1:0] cal_samples_q, cal_samples_d;
  logic                       reg_sel;
  logic                       accept;
  logic                       out_block;
  gbci_pkg::lane_ctl_t        lane_ctl;
  gbci_pkg::out_ctl_t         out_ctl;
  logic signed [gbci_pkg::ACC_W-1:0] acc_x, acc_y, acc_z;

  // register file: word-aligned decode, low address bits are ignored
  assign pready  = 1'b1;
  assign reg_sel = (paddr[gbci_pkg::APB_AW-1] == gbci_pkg::REG_CAL_SAMPLES);
  assign cal_samples_d = (psel && penable && pwrite && reg_sel)
                       ? pwdata[gbci_pkg::CNT_W-1:0] : cal_samples_q;
  assign prdata = reg_sel
                ? {{(gbci_pkg::APB_DW-gbci_pkg::CNT_W){1'b0}}, cal_samples_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_samples_q <= gbci_pkg::CAL_SAMPLES_RST;
    end else begin
      cal_samples_q <= cal_samples_d;
    end
  end

  // input handshake
  assign accept = in_i.valid && in_i.ready;

  gbci_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .mode_i        (in_i.mode),
    .cal_samples_i (cal_samples_q),
    .out_block_i   (out_block),
    .in_ready_o    (in_i.ready),
    .lane_ctl_o    (lane_ctl),
    .out_ctl_o     (out_ctl)
  );

  // one lane per axis, all driven by the same control word
  gbci_lane u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (lane_ctl),
    .sample_i (in_i.rate_x),
    .acc_o    (acc_x)
  );

  gbci_lane u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (lane_ctl),
    .sample_i (in_i.rate_y),
    .acc_o    (acc_y)
  );

  gbci_lane u_lane_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (lane_ctl),
    .sample_i (in_i.rate_z),
    .acc_o    (acc_z)
  );

  // result register joins the lanes into one item
  gbci_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (out_ctl),
    .acc_x_i (acc_x),
    .acc_y_i (acc_y),
    .acc_z_i (acc_z),
    .block_o (out_block),
    .out_o   (out_o)
  );

endmodule

@@ design/gbci_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer: stack pointer, merge degrees, calibration count and lane control
module gbci_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           mode_i,
  input  logic [gbci_pkg::CNT_W-1:0]     cal_samples_i,
  input  logic                           out_block_i,
  output logic                           in_ready_o,
  output gbci_pkg::lane_ctl_t            lane_ctl_o,
  output gbci_pkg::out_ctl_t             out_ctl_o
);

  gbci_pkg::state_e                state_q, state_d;
  logic [gbci_pkg::TOP_W-1:0]      top_q, top_d;
  logic [gbci_pkg::CNT_W-1:0]      count_q, count_d;
  logic [gbci_pkg::DEG_W-1:0]      cdeg_q, cdeg_d;
  logic                            seen_q, seen_d;
  logic [gbci_pkg::DEG_W-1:0]      deg_q [gbci_pkg::STACK_DEPTH];

  logic [gbci_pkg::TOP_W-1:0]      top_m1;
  logic [gbci_pkg::IDX_W-1:0]      rd_idx;
  logic [gbci_pkg::IDX_W-1:0]      wr_idx;
  logic                            match;
  logic [gbci_pkg::CNT_W:0]        cnt_inc;
  logic [gbci_pkg::CNT_W:0]        limit;
  logic                            deg_we;

  assign top_m1 = top_q - gbci_pkg::TOP_W'(1);
  assign rd_idx = top_m1[gbci_pkg::IDX_W-1:0];
  assign wr_idx = top_q[gbci_pkg::IDX_W-1:0];
  assign match  = (top_q != '0) && (deg_q[rd_idx] == cdeg_q);
  assign cnt_inc = {1'b0, count_q} + (gbci_pkg::CNT_W+1)'(1);
  // a zero run length behaves like one
  assign limit  = (cal_samples_i == '0) ? (gbci_pkg::CNT_W+1)'(1) : {1'b0, cal_samples_i};
  assign in_ready_o = (state_q == gbci_pkg::S_IDLE);

  always_comb begin
    state_d    = state_q;
    top_d      = top_q;
    count_d    = count_q;
    cdeg_d     = cdeg_q;
    seen_d     = seen_q;
    deg_we     = 1'b0;
    lane_ctl_o = '0;
    lane_ctl_o.rd_idx = rd_idx;
    lane_ctl_o.wr_idx = wr_idx;
    out_ctl_o  = '0;
    out_ctl_o.seen = seen_q;
    case (state_q)
      gbci_pkg::S_IDLE: begin
        if (accept_i) begin
          lane_ctl_o.load = 1'b1;
          cdeg_d = '0;
          if (mode_i) begin
            state_d = gbci_pkg::S_RUN;
          end else if (top_q == gbci_pkg::TOP_W'(gbci_pkg::STACK_DEPTH)) begin
            // stack full: sample dropped but still counted
            state_d = gbci_pkg::S_FINISH;
          end else begin
            state_d = gbci_pkg::S_MERGE;
          end
        end
      end
      gbci_pkg::S_MERGE: begin
        if (match) begin
          lane_ctl_o.merge = 1'b1;
          cdeg_d = cdeg_q + gbci_pkg::DEG_W'(1);
          top_d  = top_m1;
        end else begin
          lane_ctl_o.store = 1'b1;
          deg_we  = 1'b1;
          top_d   = top_q + gbci_pkg::TOP_W'(1);
          state_d = gbci_pkg::S_FINISH;
        end
      end
      gbci_pkg::S_FINISH: begin
        if (!out_block_i) begin
          out_ctl_o.emit = 1'b1;
          state_d = gbci_pkg::S_IDLE;
          if (cnt_inc >= limit) begin
            lane_ctl_o.latch_bias = 1'b1;
            out_ctl_o.done = 1'b1;
            out_ctl_o.seen = 1'b1;
            seen_d  = 1'b1;
            top_d   = '0;
            count_d = '0;
          end else begin
            count_d = cnt_inc[gbci_pkg::CNT_W-1:0];
          end
        end
      end
      gbci_pkg::S_RUN: begin
        if (!out_block_i) begin
          out_ctl_o.emit     = 1'b1;
          lane_ctl_o.acc_upd = 1'b1;
          state_d = gbci_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gbci_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbci_pkg::S_IDLE;
      top_q   <= '0;
      count_q <= '0;
      cdeg_q  <= '0;
      seen_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      count_q <= count_d;
      cdeg_q  <= cdeg_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_q[wr_idx] <= cdeg_q;
    end
  end

endmodule

@@ design/gbci_lane.sv @@
`timescale 1ns / 1ps
// one axis lane: partial average stack, merge adder, bias and orientation accumulator
module gbci_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gbci_pkg::lane_ctl_t                 ctl_i,
  input  logic signed [gbci_pkg::RATE_W-1:0]  sample_i,
  output logic signed [gbci_pkg::ACC_W-1:0]   acc_o
);

  logic signed [gbci_pkg::RATE_W-1:0] stack_q [gbci_pkg::STACK_DEPTH];
  logic signed [gbci_pkg::RATE_W-1:0] carry_q, carry_d;
  logic signed [gbci_pkg::RATE_W-1:0] bias_q, bias_d;
  logic signed [gbci_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic signed [gbci_pkg::RATE_W:0]   sum;
  logic signed [gbci_pkg::RATE_W:0]   diff;

  // floor average of the entry below and the carried top entry
  assign sum  = {stack_q[ctl_i.rd_idx][gbci_pkg::RATE_W-1], stack_q[ctl_i.rd_idx]}
              + {carry_q[gbci_pkg::RATE_W-1], carry_q};
  assign diff = {carry_q[gbci_pkg::RATE_W-1], carry_q}
              - {bias_q[gbci_pkg::RATE_W-1], bias_q};

  always_comb begin
    carry_d = carry_q;
    if (ctl_i.load) begin
      carry_d = sample_i;
    end else if (ctl_i.merge) begin
      carry_d = sum[gbci_pkg::RATE_W:1];
    end
  end

  assign bias_d = ctl_i.latch_bias ? stack_q[0] : bias_q;
  assign acc_d  = ctl_i.acc_upd
                ? acc_q + {{(gbci_pkg::ACC_W-gbci_pkg::RATE_W-1){diff[gbci_pkg::RATE_W]}}, diff}
                : acc_q;
  assign acc_o  = acc_d;

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (ctl_i.store) begin
      stack_q[ctl_i.wr_idx] <= carry_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= '0;
      acc_q  <= '0;
    end else begin
      bias_q <= bias_d;
      acc_q  <= acc_d;
    end
  end

endmodule

@@ design/gbci_out.sv @@
`timescale 1ns / 1ps
// merge stage: gathers the three lanes into one registered result item
module gbci_out (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  gbci_pkg::out_ctl_t                 ctl_i,
  input  logic signed [gbci_pkg::ACC_W-1:0]  acc_x_i,
  input  logic signed [gbci_pkg::ACC_W-1:0]  acc_y_i,
  input  logic signed [gbci_pkg::ACC_W-1:0]  acc_z_i,
  output logic                               block_o,
  gbci_out_if.source                         out_o
);

  logic                              valid_q, valid_d;
  logic signed [gbci_pkg::ACC_W-1:0] ox_q, oy_q, oz_q;
  logic                              done_q, seen_q;

  assign block_o = valid_q && !out_o.ready;
  assign valid_d = ctl_i.emit ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      ox_q   <= acc_x_i;
      oy_q   <= acc_y_i;
      oz_q   <= acc_z_i;
      done_q <= ctl_i.done;
      seen_q <= ctl_i.seen;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.orient_x   = ox_q;
  assign out_o.orient_y   = oy_q;
  assign out_o.orient_z   = oz_q;
  assign out_o.cal_done   = done_q;
  assign out_o.bias_valid = seen_q;

endmodule
